// ===== rtl/f32c_pkg.sv =====
// ----------------------------------------------------------------------------
// f32c_pkg
// Shared types, constants and the ones'-complement adder of the Fletcher-32
// checksum block.
// ----------------------------------------------------------------------------
package f32c_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned SUM_W   = 32;

    localparam logic [SUM_W-1:0] INIT_VALUE_RST = 32'hFFFF_FFFF;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [WORD_W-1:0] t_word;
    typedef logic [SUM_W-1:0]  t_sum;

    // input register contents handed to the accumulator
    typedef struct packed {
        logic  valid;
        t_byte data_byte;
        logic  last;
    } t_stage;

    // 16-bit add with end-around carry
    function automatic t_word oc_add16(input t_word a, input t_word b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WORD_W-1:0] + t_word'(s[WORD_W]);
    endfunction

endpackage

// ===== rtl/f32c_if.sv =====
// ----------------------------------------------------------------------------
// f32c_byte_if / f32c_sum_if
// Valid/ready channels for message bytes and checksum results.
// ----------------------------------------------------------------------------
interface f32c_byte_if
    import f32c_pkg::*;
;
    logic  valid;
    logic  ready;
    t_byte data_byte;
    logic  last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface f32c_sum_if
    import f32c_pkg::*;
;
    logic valid;
    logic ready;
    t_sum checksum;

    modport source (output valid, output checksum, input ready);
    modport sink   (input valid, input checksum, output ready);
endinterface

// ===== rtl/f32c_in_stage.sv =====
// ----------------------------------------------------------------------------
// f32c_in_stage
// Input register: captures one byte per transfer and holds it until the
// accumulator takes it.
// ----------------------------------------------------------------------------
module f32c_in_stage
    import f32c_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    f32c_byte_if.sink    i_byte,
    input  logic         i_advance,
    output t_stage       o_stage
);

    logic  r_valid, n_valid;
    t_byte r_data_byte;
    logic  r_last;
    logic  take;

    assign i_byte.ready = !r_valid || i_advance;
    assign take         = i_byte.valid && i_byte.ready;

    always_comb begin
        n_valid = r_valid;
        if (take) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_data_byte <= i_byte.data_byte;
            r_last      <= i_byte.last;
        end
    end

    assign o_stage = '{valid: r_valid, data_byte: r_data_byte, last: r_last};

endmodule

// ===== rtl/f32c_accum.sv =====
// ----------------------------------------------------------------------------
// f32c_accum
// Running sums, word assembly, seed register and checksum output register.
// ----------------------------------------------------------------------------
module f32c_accum
    import f32c_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_stage        i_stage,
    output logic          o_advance,
    input  logic          i_cfg_we,
    input  t_sum          i_cfg_wdata,
    f32c_sum_if.source    o_sum
);

    t_sum  r_init;
    t_word r_first, n_first;
    t_word r_second, n_second;
    t_byte r_hold, n_hold;
    logic  r_pending, n_pending;
    logic  r_out_valid, n_out_valid;
    t_sum  r_checksum;
    logic  out_free;
    t_word fs_upd;
    t_word ss_upd;

    assign out_free  = !r_out_valid || o_sum.ready;
    assign o_advance = i_stage.valid && (!i_stage.last || out_free);

    assign fs_upd = oc_add16(r_first, {r_hold, i_stage.data_byte});
    assign ss_upd = oc_add16(r_second, fs_upd);

    always_comb begin
        n_first     = r_first;
        n_second    = r_second;
        n_hold      = r_hold;
        n_pending   = r_pending;
        n_out_valid = r_out_valid && !o_sum.ready;
        if (i_cfg_we) begin
            n_first   = i_cfg_wdata[WORD_W-1:0];
            n_second  = i_cfg_wdata[SUM_W-1:WORD_W];
            n_hold    = '0;
            n_pending = 1'b0;
        end else if (o_advance) begin
            if (r_pending) begin
                n_first   = fs_upd;
                n_second  = ss_upd;
                n_hold    = '0;
                n_pending = 1'b0;
            end else if (!i_stage.last) begin
                n_hold    = i_stage.data_byte;
                n_pending = 1'b1;
            end
            if (i_stage.last) begin
                n_out_valid = 1'b1;
                n_first     = r_init[WORD_W-1:0];
                n_second    = r_init[SUM_W-1:WORD_W];
                n_hold      = '0;
                n_pending   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init      <= INIT_VALUE_RST;
            r_first     <= INIT_VALUE_RST[WORD_W-1:0];
            r_second    <= INIT_VALUE_RST[SUM_W-1:WORD_W];
            r_hold      <= '0;
            r_pending   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_init <= i_cfg_wdata;
            end
            r_first     <= n_first;
            r_second    <= n_second;
            r_hold      <= n_hold;
            r_pending   <= n_pending;
            r_out_valid <= n_out_valid;
        end
    end

    // pending word completes on the last byte: checksum includes it
    always_ff @(posedge i_clk) begin
        if (o_advance && i_stage.last) begin
            r_checksum <= r_pending ? {ss_upd, fs_upd} : {r_second, r_first};
        end
    end

    assign o_sum.valid    = r_out_valid;
    assign o_sum.checksum = r_checksum;

endmodule

// ===== rtl/fletcher32_checksum.sv =====
// ----------------------------------------------------------------------------
// fletcher32_checksum
// Streaming Fletcher-32 over big-endian 16-bit words, one byte per clock.
//
//   channel    dir  handshake        payload
//   i_byte     in   valid / ready    data_byte[7:0], last
//   o_sum      out  valid / ready    checksum[31:0]
//   cfg        in   i_cfg_we         i_cfg_wdata[31:0] (initial_value)
//
// One byte per cycle while the checksum output is not stalled; a checksum is
// valid once the last byte has been taken into the input register and the
// sum update has then loaded the output register.
// Synchronous active-low reset: seed 0xFFFFFFFF, both channels empty.
// A stalled checksum holds the input only when the staged byte is also last.
// ----------------------------------------------------------------------------
module fletcher32_checksum
    import f32c_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    f32c_byte_if.sink     i_byte,
    f32c_sum_if.source    o_sum,
    input  logic          i_cfg_we,
    input  t_sum          i_cfg_wdata
);

    t_stage stage;
    logic   advance;

    f32c_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (i_byte),
        .i_advance (advance),
        .o_stage   (stage)
    );

    f32c_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stage     (stage),
        .o_advance   (advance),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_sum       (o_sum)
    );

endmodule

// ===== rtl/f32c_checker.sv =====
// ----------------------------------------------------------------------------
// f32c_checker
// Port-level checks on the checksum block, bound to the top level.
// ----------------------------------------------------------------------------
module f32c_checker
    import f32c_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input t_sum i_checksum
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("checksum dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_checksum))
        else $error("checksum changed while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("checksum valid after reset");

    a_block_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input blocked without a stalled checksum");

    a_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_in_valid) && $past(!i_out_valid) |-> i_in_ready)
        else $error("input not ready on an idle block");

endmodule

bind fletcher32_checksum f32c_checker u_f32c_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_byte.valid),
    .i_in_ready  (i_byte.ready),
    .i_out_valid (o_sum.valid),
    .i_out_ready (o_sum.ready),
    .i_checksum  (o_sum.checksum)
);

// ===== tb/sv/fletcher32_checksum_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fletcher32_checksum_test
// Self-checking bench for the streaming Fletcher-32 block. Byte messages go in
// through the valid/ready byte channel, and each checksum coming out is
// compared with a bit-true model of the two ones'-complement sums. Directed
// cases cover byte and seed extremes, odd and one-byte messages and seed
// writes. They are followed by random messages with random gaps and
// backpressure, and a final stretch at full rate.
// ----------------------------------------------------------------------------
module fletcher32_checksum_test;
    import f32c_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int STALL_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_BYTES  = 540;
    localparam int STEADY_BYTES  = 110;

    logic clk;
    logic rst_n;
    logic cfg_we;
    t_sum cfg_wdata;

    f32c_byte_if byte_ch ();
    f32c_sum_if  sum_ch ();

    fletcher32_checksum dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_byte      (byte_ch),
        .o_sum       (sum_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // checksum model state
    t_sum  seed_value;
    t_word sum_a;
    t_word sum_b;
    t_byte held_byte;
    logic  held_valid;

    t_sum expected_sums[$];
    int   mismatches = 0;
    int   bytes_sent = 0;
    bit   steady     = 1'b0;

    function automatic t_word ones_add16(input t_word x, input t_word y);
        logic [16:0] total;
        total = 17'(x) + 17'(y);
        return total[15:0] + {15'd0, total[16]};
    endfunction

    function automatic void reseed_sums();
        sum_a      = seed_value[15:0];
        sum_b      = seed_value[31:16];
        held_byte  = '0;
        held_valid = 1'b0;
    endfunction

    function automatic bit fletcher_step(input t_byte b, input logic l, output t_sum sum);
        sum = '0;
        if (held_valid) begin
            sum_a      = ones_add16(sum_a, {held_byte, b});
            sum_b      = ones_add16(sum_b, sum_a);
            held_valid = 1'b0;
            held_byte  = '0;
        end else if (!l) begin
            held_byte  = b;
            held_valid = 1'b1;
        end
        if (l) begin
            sum = {sum_b, sum_a};
            reseed_sums();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input t_sum got, input t_sum want);
        $display("ERROR %0t: %s: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // checksum sink with random stall bursts
    initial begin
        int stall_left;
        stall_left   = 0;
        sum_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                sum_ch.ready <= 1'b0;
                stall_left--;
            end else if (!steady && $urandom_range(0, 9) == 0) begin
                sum_ch.ready <= 1'b0;
                stall_left = $urandom_range(1, 17) - 1;
            end else begin
                sum_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && sum_ch.valid && sum_ch.ready) begin
            if (expected_sums.size() == 0) begin
                report_mismatch("unexpected checksum", sum_ch.checksum, '0);
            end else begin
                t_sum want;
                want = expected_sums.pop_front();
                if (sum_ch.checksum !== want) begin
                    report_mismatch("checksum", sum_ch.checksum, want);
                end
            end
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((byte_ch.valid && byte_ch.ready) || (sum_ch.valid && sum_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("ERROR: no transfer for %0d cycles", STALL_LIMIT);
        $display("fletcher32_checksum test failed");
        $finish;
    end

    task automatic send_byte(input t_byte b, input logic l);
        int   gap;
        t_sum sum;
        gap = 0;
        if (!steady && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 17);
        end
        repeat (gap) begin
            @(negedge clk);
            byte_ch.valid <= 1'b0;
        end
        @(negedge clk);
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.last      <= l;
        do @(posedge clk); while (!byte_ch.ready);
        bytes_sent++;
        if (fletcher_step(b, l, sum)) begin
            expected_sums.push_back(sum);
        end
    endtask

    task automatic send_message(input t_byte msg[$]);
        foreach (msg[i]) begin
            send_byte(msg[i], i == msg.size() - 1);
        end
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        byte_ch.valid <= 1'b0;
        while (expected_sums.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_initial_value(input t_sum value);
        wait_for_results();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        seed_value = value;
        reseed_sums();
    endtask

    task automatic test_one_byte_message();
        send_message({8'hA5});
    endtask

    task automatic test_byte_extremes();
        send_message({8'hFF, 8'hFF, 8'h00, 8'h00});
        send_message({8'h80, 8'h01, 8'h7F});
    endtask

    task automatic test_seed_extremes();
        set_initial_value(32'h0000_0000);
        send_message({8'h00, 8'h00});
        send_message({8'hFF, 8'hFF});
        set_initial_value(32'hFFFF_0000);
        send_message({8'h12, 8'h34});
        set_initial_value(32'h0000_FFFF);
        send_message({8'hFF, 8'hFE, 8'h00, 8'h01});
    endtask

    // seed write drops a half word left waiting
    task automatic test_write_clears_half_word();
        send_byte(8'h55, 1'b0);
        set_initial_value(32'h1234_5678);
        send_message({8'h01, 8'h02});
    endtask

    task automatic build_random_message(input int len, output t_byte msg[$]);
        int fill;
        fill = $urandom_range(0, 9);
        msg  = {};
        repeat (len) begin
            case (fill)
                0:       msg.push_back(8'hFF);
                1:       msg.push_back(8'h00);
                default: msg.push_back(t_byte'($urandom));
            endcase
        end
    endtask

    task automatic test_random_messages();
        t_byte msg[$];
        int    len;
        while (bytes_sent < RANDOM_BYTES) begin
            case ($urandom_range(0, 9))
                0:       len = $urandom_range(1, 3);
                1, 2:    len = $urandom_range(17, 40);
                default: len = $urandom_range(1, 16);
            endcase
            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 4))
                    0:       set_initial_value(32'h0000_0000);
                    1:       set_initial_value(32'hFFFF_FFFF);
                    default: set_initial_value(t_sum'($urandom));
                endcase
            end else if ($urandom_range(0, 11) == 0) begin
                wait_for_results();
            end
            build_random_message(len, msg);
            send_message(msg);
        end
    endtask

    task automatic test_back_to_back();
        t_byte msg[$];
        int    stop_at;
        stop_at = bytes_sent + STEADY_BYTES;
        set_initial_value(t_sum'($urandom));
        while (bytes_sent < stop_at) begin
            build_random_message($urandom_range(1, 12), msg);
            send_message(msg);
        end
    endtask

    initial begin
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.last      = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        rst_n             = 1'b0;
        seed_value        = INIT_VALUE_RST;
        reseed_sums();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_one_byte_message();
        test_byte_extremes();
        test_seed_extremes();
        test_write_clears_half_word();
        test_random_messages();
        steady = 1'b1;
        test_back_to_back();
        wait_for_results();

        if (mismatches == 0) begin
            $display("fletcher32_checksum test passed");
        end else begin
            $display("fletcher32_checksum test failed");
        end
        $finish;
    end

endmodule
